// ----- design/line_log_ring_buffer_defines.svh -----
`ifndef LINE_LOG_RING_BUFFER_DEFINES_SVH
`define LINE_LOG_RING_BUFFER_DEFINES_SVH

// Same-cycle implication, checked on every rising clk edge outside reset.
`define LLRB_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked on every rising clk edge outside reset.
`define LLRB_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- design/llrb_pkg.sv -----
`default_nettype none

package llrb_pkg;

  localparam int DATA_W = 8;
  localparam int LEN_W  = 7;
  localparam int CMD_W  = 2;

  localparam logic [DATA_W-1:0] NEWLINE = 8'h0A;

  localparam logic [CMD_W-1:0] CMD_APPEND = 2'd0;
  localparam logic [CMD_W-1:0] CMD_POLL   = 2'd1;
  localparam logic [CMD_W-1:0] CMD_READ   = 2'd2;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DROP,
    ST_SCAN_ADDR,
    ST_SCAN_CHK,
    ST_EMIT
  } state_t;

  typedef enum logic [1:0] {
    ADDR_RP,
    ADDR_SCAN,
    ADDR_EMIT
  } addr_sel_t;

  typedef struct packed {
    logic      append;
    logic      drop;
    logic      put_poll;
    logic      put_empty;
    logic      scan_init;
    logic      scan_chk;
    logic      emit_rd;
    addr_sel_t addr_sel;
  } ctl_t;

  typedef struct packed {
    logic full;
    logic scan_end;
    logic nl_hit;
    logic emit_last;
  } stat_t;

endpackage

`default_nettype wire

// ----- design/llrb_ctrl.sv -----
`default_nettype none

module llrb_ctrl
  import llrb_pkg::*;
(
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             start,
  input  wire logic [CMD_W-1:0] command,
  input  wire stat_t            stat,
  output ctl_t                  ctl,
  output logic                  busy
);

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next   = state;
    ctl          = '0;
    ctl.addr_sel = ADDR_RP;
    unique case (state)
      ST_IDLE: begin
        if (start) begin
          unique case (command)
            CMD_APPEND: begin
              ctl.append = 1'b1;
              // full ring: fetch the oldest byte now, drop it next cycle
              if (stat.full) begin
                state_next = ST_DROP;
              end
            end
            CMD_POLL: begin
              ctl.put_poll = 1'b1;
            end
            CMD_READ: begin
              ctl.scan_init = 1'b1;
              state_next    = ST_SCAN_ADDR;
            end
            default: begin
            end
          endcase
        end
      end
      ST_DROP: begin
        ctl.drop   = 1'b1;
        state_next = ST_IDLE;
      end
      ST_SCAN_ADDR: begin
        ctl.addr_sel = ADDR_SCAN;
        if (stat.scan_end) begin
          ctl.put_empty = 1'b1;
          state_next    = ST_IDLE;
        end else begin
          state_next = ST_SCAN_CHK;
        end
      end
      ST_SCAN_CHK: begin
        ctl.scan_chk = 1'b1;
        state_next   = stat.nl_hit ? ST_EMIT : ST_SCAN_ADDR;
      end
      ST_EMIT: begin
        ctl.emit_rd  = 1'b1;
        ctl.addr_sel = ADDR_EMIT;
        if (stat.emit_last) begin
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  assign busy = (state != ST_IDLE);

endmodule

`default_nettype wire

// ----- design/llrb_datapath.sv -----
`default_nettype none

module llrb_datapath
  import llrb_pkg::*;
#(
  parameter int RING_DEPTH = 8192,
  parameter int MAX_LINE   = 64
) (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic [DATA_W-1:0] data_byte,
  input  wire logic [LEN_W-1:0]  max_len,
  input  wire ctl_t              ctl,
  output stat_t                  stat,
  output logic                   result_valid,
  output logic [DATA_W-1:0]      out_byte,
  output logic                   byte_valid,
  output logic                   line_ready,
  output logic [LEN_W-1:0]       line_length,
  output logic                   last
);

  localparam int AW = (RING_DEPTH > 1) ? $clog2(RING_DEPTH) : 1;
  localparam logic [LEN_W-1:0] LIMIT_MAX = LEN_W'(MAX_LINE);

  function automatic logic [AW-1:0] ring_next(input logic [AW-1:0] p);
    return (p == AW'(RING_DEPTH - 1)) ? '0 : AW'(p + 1'b1);
  endfunction

  logic [DATA_W-1:0] mem [RING_DEPTH];
  logic [DATA_W-1:0] rd_q;
  logic [AW-1:0]     rd_addr;

  logic [AW-1:0]    wp, rp, nl_cnt;
  logic [AW-1:0]    scan_ptr, emit_ptr;
  logic [LEN_W-1:0] lim, scan_cnt, len, emit_cnt;

  always_comb begin
    unique case (ctl.addr_sel)
      ADDR_SCAN: rd_addr = scan_ptr;
      ADDR_EMIT: rd_addr = emit_ptr;
      default:   rd_addr = rp;
    endcase
  end

  always_ff @(posedge clk) begin
    if (ctl.append) begin
      mem[wp] <= data_byte;
    end
    rd_q <= mem[rd_addr];
  end

  // pointers and newline count
  always_ff @(posedge clk) begin
    if (rst) begin
      wp     <= '0;
      rp     <= '0;
      nl_cnt <= '0;
    end else begin
      priority if (ctl.append) begin
        wp <= ring_next(wp);
        if (data_byte == NEWLINE) begin
          nl_cnt <= nl_cnt + 1'b1;
        end
      end else if (ctl.drop) begin
        rp <= ring_next(rp);
        if (rd_q == NEWLINE) begin
          nl_cnt <= nl_cnt - 1'b1;
        end
      end else if (ctl.emit_rd && stat.emit_last) begin
        // consume the line, its newline included
        rp     <= ring_next(emit_ptr);
        nl_cnt <= nl_cnt - 1'b1;
      end
    end
  end

  // scan and emit counters
  always_ff @(posedge clk) begin
    if (ctl.scan_init) begin
      lim      <= (max_len > LIMIT_MAX) ? LIMIT_MAX : max_len;
      scan_ptr <= rp;
      scan_cnt <= '0;
    end
    if (ctl.scan_chk) begin
      scan_ptr <= ring_next(scan_ptr);
      scan_cnt <= scan_cnt + 1'b1;
      if (stat.nl_hit) begin
        len      <= scan_cnt + 1'b1;
        emit_ptr <= rp;
        emit_cnt <= '0;
      end
    end
    if (ctl.emit_rd) begin
      emit_ptr <= ring_next(emit_ptr);
      emit_cnt <= emit_cnt + 1'b1;
    end
  end

  // result register, out_byte comes from the memory read register
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else begin
      result_valid <= ctl.put_poll | ctl.put_empty | ctl.emit_rd;
    end
    byte_valid  <= ctl.emit_rd;
    line_ready  <= ctl.put_poll & (nl_cnt != '0);
    last        <= ctl.put_poll | ctl.put_empty | (ctl.emit_rd & stat.emit_last);
    line_length <= (ctl.emit_rd && stat.emit_last) ? len : '0;
  end

  assign out_byte = byte_valid ? rd_q : '0;

  assign stat.full      = (ring_next(wp) == rp);
  assign stat.scan_end  = (scan_ptr == wp) || (scan_cnt == lim);
  assign stat.nl_hit    = (rd_q == NEWLINE);
  assign stat.emit_last = (emit_cnt == LEN_W'(len - 1'b1));

endmodule

`default_nettype wire

// ----- design/line_log_ring_buffer.sv -----
// Append: when the ring is full, the oldest byte is also dropped, in the ST_DROP state.
// Poll: its result shows in the cycle after the request is accepted.
// Read of an L-byte line: each scanned byte takes a memory read, then a compare,
// then one result per cycle; results cannot be stalled.
// Reset clears both pointers, the newline count and the controller; the ring
// memory is not cleared and needs no clearing pass.
`default_nettype none
`include "line_log_ring_buffer_defines.svh"

module line_log_ring_buffer
  import llrb_pkg::*;
#(
  parameter int RING_DEPTH = 8192,
  parameter int MAX_LINE   = 64
) (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              start,
  output logic                   busy,
  input  wire logic [CMD_W-1:0]  command,
  input  wire logic [DATA_W-1:0] data_byte,
  input  wire logic [LEN_W-1:0]  max_len,
  output logic                   result_valid,
  output logic [DATA_W-1:0]      out_byte,
  output logic                   byte_valid,
  output logic                   line_ready,
  output logic [LEN_W-1:0]       line_length,
  output logic                   last
);

  ctl_t  ctl;
  stat_t stat;

  llrb_ctrl u_ctrl (
    .clk     (clk),
    .rst     (rst),
    .start   (start),
    .command (command),
    .stat    (stat),
    .ctl     (ctl),
    .busy    (busy)
  );

  llrb_datapath #(
    .RING_DEPTH (RING_DEPTH),
    .MAX_LINE   (MAX_LINE)
  ) u_datapath (
    .clk          (clk),
    .rst          (rst),
    .data_byte    (data_byte),
    .max_len      (max_len),
    .ctl          (ctl),
    .stat         (stat),
    .result_valid (result_valid),
    .out_byte     (out_byte),
    .byte_valid   (byte_valid),
    .line_ready   (line_ready),
    .line_length  (line_length),
    .last         (last)
  );

  `LLRB_ASSERT_NOW(a_line_len, result_valid && byte_valid && last, line_length != '0, "line end with zero length")
  `LLRB_ASSERT_NEXT(a_line_cont, result_valid && byte_valid && !last, result_valid && byte_valid, "gap inside a line")
  `LLRB_ASSERT_NEXT(a_emit_end, ctl.emit_rd && stat.emit_last, result_valid && last && byte_valid, "last line byte not marked")
  `LLRB_ASSERT_NEXT(a_read_busy, start && !busy && command == CMD_READ, busy, "read request did not start a scan")

endmodule

`default_nettype wire
